// File: rtl/core/pflq_pkg.sv
// pflq_pkg: shared types and constants for the prime filtered linear queue.
// No dependencies.
`default_nettype none
package pflq_pkg;
    localparam int DEPTH = 128;
    localparam int AW = $clog2(DEPTH);
    localparam logic [1:0] FN_PRIME = 2'd0;
    localparam logic [1:0] FN_PUSH  = 2'd1;
    localparam logic [1:0] FN_POP   = 2'd2;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_UNF   = 2'd2;
    localparam logic [1:0] ST_NPRM  = 2'd3;
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] value;
        logic        is_prime;
    } t_cmd;
endpackage
`default_nettype wire

// File: rtl/core/pflq_front.sv
// pflq_front: accepts beats and tests primality by iterative trial division.
// Depends on pflq_pkg. One restoring-division step per cycle.
`default_nettype none
module pflq_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [1:0]    i_func,
    input  wire logic [31:0]   i_value_in,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_stall,
    output pflq_pkg::t_cmd     o_cmd
);
    import pflq_pkg::*;
    localparam logic [1:0] S_IDLE = 2'd0, S_DIV = 2'd1, S_OUT = 2'd2;
    logic [1:0]  r_st, n_st;
    t_cmd        r_cmd, n_cmd;
    logic [31:0] r_d, n_d, r_rem, n_rem, r_quo, n_quo;
    logic [5:0]  r_bit, n_bit;
    logic [32:0] w_sh;
    logic [31:0] w_rem;
    logic        w_ge;

    assign o_stall     = (r_st != S_IDLE);
    assign o_cmd_valid = (r_st == S_OUT);
    assign o_cmd       = r_cmd;

    always_comb begin
        w_sh  = {r_rem, r_cmd.value[r_bit[4:0]]};
        w_ge  = w_sh >= {1'b0, r_d};
        w_rem = w_ge ? 32'(w_sh - {1'b0, r_d}) : w_sh[31:0];
    end

    always_comb begin
        n_st = r_st; n_cmd = r_cmd; n_d = r_d; n_rem = r_rem; n_quo = r_quo; n_bit = r_bit;
        unique case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd.func = i_func;
                    n_cmd.value = i_value_in;
                    n_cmd.is_prime = 1'b0;
                    n_d = 32'd2; n_rem = '0; n_quo = '0; n_bit = 6'd31;
                    if (i_func == FN_PRIME && !i_value_in[31] && i_value_in > 32'sd1) begin
                        n_st = S_DIV;
                        n_cmd.is_prime = 1'b1;
                    end else begin
                        n_st = S_OUT;
                    end
                end
            end
            S_DIV: begin
                n_rem = w_rem;
                n_quo = {r_quo[30:0], w_ge};
                n_bit = r_bit - 6'd1;
                if (r_bit == 6'd0) begin
                    n_rem = '0; n_quo = '0; n_bit = 6'd31;
                    if (r_d > {r_quo[30:0], w_ge}) begin
                        n_st = S_OUT;
                    end else if (w_rem == '0) begin
                        n_cmd.is_prime = 1'b0;
                        n_st = S_OUT;
                    end else begin
                        n_d = r_d + 32'd1;
                    end
                end
            end
            S_OUT: if (!i_cmd_stall) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= S_IDLE;
        else r_st <= n_st;
        r_cmd <= n_cmd; r_d <= n_d; r_rem <= n_rem; r_quo <= n_quo; r_bit <= n_bit;
    end
endmodule
`default_nettype wire

// File: rtl/core/pflq_fifo.sv
// pflq_fifo: two-entry command queue between front and back.
// Depends on pflq_pkg.
`default_nettype none
module pflq_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire pflq_pkg::t_cmd i_cmd,
    output logic               o_valid,
    input  wire logic          i_stall,
    output pflq_pkg::t_cmd     o_cmd
);
    import pflq_pkg::*;
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) r_mem[r_wp] <= i_cmd;
    end
endmodule
`default_nettype wire

// File: rtl/core/pflq_back.sv
// pflq_back: queue storage and index logic, registered result beat.
// Depends on pflq_pkg.
`default_nettype none
module pflq_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire pflq_pkg::t_cmd i_cmd,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_value_out,
    output logic               o_now_empty,
    output logic               o_now_full
);
    import pflq_pkg::*;
    logic [31:0]   r_mem [DEPTH];
    logic [AW-1:0] r_head, r_tail;
    logic          r_empty, r_pend, r_ov, r_rd;
    logic [1:0]    r_status;
    logic [31:0]   r_rdata;
    logic          w_full, w_go;

    assign w_full  = !r_empty && (r_tail == AW'(DEPTH - 1));
    assign o_stall = r_pend || r_ov;
    assign w_go    = i_valid && !o_stall;
    assign o_valid = r_ov;
    assign o_status = r_status;
    assign o_value_out = r_rd ? r_rdata : ((r_status == ST_UNF) ? '1 : '0);
    assign o_now_empty = r_empty;
    assign o_now_full  = w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0; r_tail <= '0; r_empty <= 1'b1;
            r_pend <= 1'b0; r_ov <= 1'b0; r_rd <= 1'b0; r_status <= ST_OK;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            if (r_pend) begin
                r_pend <= 1'b0;
                r_ov <= 1'b1;
            end
            if (w_go) begin
                r_pend <= 1'b1;
                unique case (i_cmd.func)
                    FN_PRIME, FN_PUSH: begin
                        r_rd <= 1'b0;
                        if (w_full) r_status <= ST_OVF;
                        else if (i_cmd.func == FN_PRIME && !i_cmd.is_prime)
                            r_status <= ST_NPRM;
                        else begin
                            r_status <= ST_OK;
                            if (r_empty) begin
                                r_head <= '0; r_tail <= '0; r_empty <= 1'b0;
                            end else r_tail <= r_tail + AW'(1);
                        end
                    end
                    FN_POP: begin
                        if (r_empty) begin
                            r_status <= ST_UNF;
                            r_rd <= 1'b0;
                        end else begin
                            r_status <= ST_OK;
                            r_rd <= 1'b1;
                            if (r_head == r_tail) begin
                                r_head <= '0; r_tail <= '0; r_empty <= 1'b1;
                            end else r_head <= r_head + AW'(1);
                        end
                    end
                    default: begin
                        r_status <= ST_OK;
                        r_rd <= 1'b0;
                    end
                endcase
            end
        end
        if (w_go && (i_cmd.func == FN_PRIME || i_cmd.func == FN_PUSH) && !w_full
            && (i_cmd.func == FN_PUSH || i_cmd.is_prime))
            r_mem[r_empty ? AW'(0) : r_tail + AW'(1)] <= i_cmd.value;
        if (w_go) r_rdata <= r_mem[r_head];
    end
endmodule
`default_nettype wire

// File: rtl/core/prime_filtered_linear_queue_top.sv
// Prime filtered linear queue: a linear array queue of signed 32-bit values
// with prime-only enqueue, plain enqueue and dequeue operations.
// Input channel: i_valid / o_stall with i_func, i_value_in, one beat per item.
// Output channel: o_valid / i_stall with o_status, o_value_out, o_now_empty,
// o_now_full, exactly one result beat per input beat, in order.
// Plain enqueue, dequeue and prime-only enqueue of a value <= 1 pass the front
// without a prime test. A prime test does one full 32-bit restoring division per
// trial divisor in the front divider (one quotient bit per cycle), with divisors
// 2 up to sqrt(value). The divider sets the rate; the back end takes no new beat
// until its previous result beat has been accepted.
// A two-entry queue separates front and back so the divider can work on the
// next item while a result waits at the output.
// Reset (synchronous, i_rst_n low) empties the queue and drops in-flight beats;
// slot contents are not cleared. When the receiver stalls, the result is held
// stable and the stall backs up through the queue to o_stall.
// Depends on pflq_pkg, pflq_front, pflq_fifo, pflq_back.
`default_nettype none
module prime_filtered_linear_queue_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [1:0]    i_func,
    input  wire logic signed [31:0] i_value_in,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_value_out,
    output logic               o_now_empty,
    output logic               o_now_full
);
    import pflq_pkg::*;
    t_cmd w_fcmd, w_bcmd;
    logic w_fv, w_fs, w_bv, w_bs;

    pflq_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_func, .i_value_in,
        .o_cmd_valid(w_fv), .i_cmd_stall(w_fs), .o_cmd(w_fcmd)
    );
    pflq_fifo u_fifo (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_stall(w_fs), .i_cmd(w_fcmd),
        .o_valid(w_bv), .i_stall(w_bs), .o_cmd(w_bcmd)
    );
    pflq_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_bv), .o_stall(w_bs), .i_cmd(w_bcmd),
        .o_valid, .i_stall, .o_status, .o_value_out, .o_now_empty, .o_now_full
    );
endmodule
`default_nettype wire

// File: tb/prime_filtered_linear_queue_top_tb.sv
// Testbench for prime_filtered_linear_queue_top: directed and random beats, with a
// scoreboard class that tracks the queue state and checks every result beat in order.
// Depends on pflq_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps
module prime_filtered_linear_queue_top_tb;
    import pflq_pkg::*;

    localparam logic [1:0] FN_NOP = 2'd3;
    localparam int LIMIT_CYCLES = 3000000;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] value_out;
        logic        now_empty;
        logic        now_full;
    } t_result;

    class queue_scoreboard;
        logic [31:0] slots [DEPTH];
        int unsigned head_idx;
        int unsigned tail_idx;
        bit          empty;
        t_result     pending [$];
        int          errors;
        int          checked;
        int          n_ovf;
        int          n_unf;
        int          n_rej;

        function new();
            head_idx = 0;
            tail_idx = 0;
            empty = 1;
            errors = 0;
            checked = 0;
        endfunction

        function bit is_prime(logic signed [31:0] v);
            longint unsigned n;
            longint unsigned d;
            if (v <= 1) return 0;
            n = v;
            for (d = 2; d * d <= n; d++)
                if (n % d == 0) return 0;
            return 1;
        endfunction

        function bit full_now();
            return !empty && tail_idx == DEPTH - 1;
        endfunction

        function void note_input(logic [1:0] fn, logic [31:0] val);
            t_result r;
            r.status = ST_OK;
            r.value_out = '0;
            if (fn == FN_PRIME || fn == FN_PUSH) begin
                if (full_now()) begin
                    r.status = ST_OVF;
                    n_ovf++;
                end else if (fn == FN_PRIME && !is_prime(val)) begin
                    r.status = ST_NPRM;
                    n_rej++;
                end else begin
                    if (empty) begin
                        head_idx = 0;
                        tail_idx = 0;
                        empty = 0;
                    end else begin
                        tail_idx++;
                    end
                    slots[tail_idx] = val;
                end
            end else if (fn == FN_POP) begin
                if (empty) begin
                    r.status = ST_UNF;
                    r.value_out = 32'hFFFF_FFFF;
                    n_unf++;
                end else begin
                    r.value_out = slots[head_idx];
                    if (head_idx == tail_idx) begin
                        head_idx = 0;
                        tail_idx = 0;
                        empty = 1;
                    end else begin
                        head_idx++;
                    end
                end
            end
            r.now_empty = empty;
            r.now_full = full_now();
            pending.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [31:0] vo, logic em, logic fu);
            t_result r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat status=%0d value=%h", $time, st, vo);
                errors++;
                return;
            end
            r = pending.pop_front();
            checked++;
            if (st !== r.status) begin
                $display("%0t: status exp %0d got %0d", $time, r.status, st);
                errors++;
            end
            if (vo !== r.value_out) begin
                $display("%0t: value_out exp %h got %h", $time, r.value_out, vo);
                errors++;
            end
            if (em !== r.now_empty) begin
                $display("%0t: now_empty exp %0d got %0d", $time, r.now_empty, em);
                errors++;
            end
            if (fu !== r.now_full) begin
                $display("%0t: now_full exp %0d got %0d", $time, r.now_full, fu);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [1:0]  i_func = FN_NOP;
    logic signed [31:0] i_value_in = '0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [1:0]  o_status;
    logic signed [31:0] o_value_out;
    logic        o_now_empty;
    logic        o_now_full;

    queue_scoreboard sb = new();
    int  cycles = 0;
    int  sent = 0;
    bit  calm = 0;
    bit  hold_done = 0;

    prime_filtered_linear_queue_top dut (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_status, o_value_out, o_now_empty, o_now_full);

    // receiver: random stalls, one long hold-off, calm stretch without stalls
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!hold_done && sent >= 300) begin
                hold_done = 1;
                i_stall <= 1;
                repeat (400) @(posedge i_clk);
            end
            i_stall <= calm ? 1'b0 : ($urandom_range(99) < 28);
        end
    end

    task automatic send(logic [1:0] fn, logic [31:0] val);
        if (!calm)
            while ($urandom_range(99) < 28) begin
                i_valid <= 0;
                @(posedge i_clk);
            end
        i_valid <= 1;
        i_func <= fn;
        i_value_in <= val;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(fn, val);
        sent++;
    endtask

    function automatic logic [31:0] prime_candidate();
        int k;
        k = $urandom_range(99);
        if (k < 60) return $urandom_range(3000);
        if (k < 75) return $urandom | 32'h8000_0000;
        if (k < 90) return $urandom & 32'hFFFF_FFFE;
        return $urandom_range(2);
    endfunction

    initial begin
        int k;
        bit filling;
        logic [1:0] fn;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send(FN_POP, 32'h1234_5678);
        send(FN_NOP, 32'hFFFF_FFFF);
        send(FN_PRIME, 32'd2);
        send(FN_PRIME, 32'd3);
        send(FN_PRIME, 32'd4);
        send(FN_PRIME, 32'd1);
        send(FN_PRIME, 32'd0);
        send(FN_PRIME, 32'hFFFF_FFFF);
        send(FN_PRIME, 32'h8000_0000);
        send(FN_PRIME, 32'h7FFF_FFFE);
        send(FN_PRIME, 32'd65521);
        send(FN_PRIME, 32'd65535);
        send(FN_PUSH, 32'h7FFF_FFFF);
        send(FN_PUSH, 32'h8000_0000);
        send(FN_PUSH, 32'hFFFF_FFFF);
        send(FN_PUSH, 32'h0);
        send(FN_NOP, 32'h0);
        repeat (7) send(FN_POP, $urandom);

        filling = 1;
        for (int i = 0; i < 1300; i++) begin
            if (i % 200 == 0) filling = !filling || i == 0;
            calm = (i >= 500 && i < 700);
            k = $urandom_range(99);
            if (k < 3) fn = FN_NOP;
            else if (k < (filling ? 88 : 30)) fn = ($urandom_range(9) < 6) ? FN_PUSH : FN_PRIME;
            else fn = FN_POP;
            send(fn, fn == FN_PRIME ? prime_candidate() : $urandom);
        end
        calm = 0;
        i_valid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("%0d beats sent, %0d results checked: %0d overflow, %0d underflow, %0d rejected",
                 sent, sb.checked, sb.n_ovf, sb.n_unf, sb.n_rej);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("status: fail");
        end
        $finish;
    end
endmodule
